// ===== sv/wsfr_pkg.sv =====
// Package for the weighted-sum frame receiver.
// Holds the field widths, protocol codes, phase type and the item and result structs.
// No dependencies.
package wsfr_pkg;

	localparam int unsigned MAX_LEN = 64;
	localparam logic [7:0] ACCEPT_LIMIT_RESET = 8'd64;

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_TIMEOUT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_DATA  = 3'd1,
		PH_SUMH  = 3'd2,
		PH_SUML  = 3'd3,
		PH_DRAIN = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_TOO_LONG = 2'd0,
		ERR_TIMEOUT  = 2'd1,
		ERR_SUM_HIGH = 2'd2,
		ERR_SUM_LOW  = 2'd3
	} err_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       present;
		kind_t      result_kind;
		logic [7:0] payload_byte;
		logic [7:0] frame_length;
		err_t       error_code;
	} result_t;

endpackage

// ===== sv/wsfr_if.sv =====
// Channel interfaces for the weighted-sum frame receiver: received items and results.
// Depends on wsfr_pkg.
interface wsfr_item_if;
	import wsfr_pkg::*;

	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface wsfr_result_if;
	import wsfr_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] payload_byte;
	logic [7:0] frame_length;
	logic [1:0] error_code;

	modport source (output valid, output result_kind, output payload_byte,
		output frame_length, output error_code, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input frame_length, input error_code, output ready);
endinterface

// ===== sv/weighted_sum_frame_receiver_unit.sv =====
// Top level of the weighted-sum frame receiver: input register, step logic and result register.
// Depends on wsfr_pkg, the channel interfaces in wsfr_if.sv and wsfr_step.
//
// Usage: item_ch carries one transaction per received byte (operation 0) or per read
// timeout (operation 1). A frame is a length byte, that many payload bytes, then the
// high and low bytes of a 16-bit sum of each byte times its position. result_ch carries
// one transaction per forwarded payload byte, per accepted frame and per frame error;
// length bytes, checksum bytes that match, idle timeouts and bytes after a good frame
// give no transaction.
// The item waits in the input register and its result is then caught in the result register.
// Throughput: one item per cycle while result_ch is not stalled, set by the single
// multiply-accumulate between the two registers.
// cfg_we with cfg_data writes the accept limit; the user must write it only while the block is idle (not enforced).
// Reset clears both registers' valid flags, returns the frame state to waiting for a
// length byte and sets the accept limit to 64.
// When result_ch is stalled the waiting result holds; one further item is still taken
// into the input register, after which item_ch ready drops until the result is taken.
module weighted_sum_frame_receiver_unit (
	input  logic       clk,
	input  logic       arst_n,
	wsfr_item_if.sink  item_ch,
	wsfr_result_if.source result_ch,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data
);
	import wsfr_pkg::*;

	logic [7:0] limit_q;
	logic       valid_s1;
	item_t      item_s1;
	logic       out_valid_q;
	result_t    out_q;
	result_t    step_res;
	logic       in_fire;
	logic       step_fire;

	assign step_fire     = valid_s1 && (!out_valid_q || result_ch.ready);
	assign item_ch.ready = !valid_s1 || step_fire;
	assign in_fire       = item_ch.valid && item_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ACCEPT_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ch.ready) begin
			valid_s1 <= item_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= '{operation: op_t'(item_ch.operation), rx_byte: item_ch.rx_byte};
		end
	end

	wsfr_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (step_fire),
		.item         (item_s1),
		.accept_limit (limit_q),
		.res          (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_fire && step_res.present) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire && step_res.present) begin
			out_q <= step_res;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.result_kind  = out_q.result_kind;
	assign result_ch.payload_byte = out_q.payload_byte;
	assign result_ch.frame_length = out_q.frame_length;
	assign result_ch.error_code   = out_q.error_code;

	// An accepted frame never reports a length beyond either limit.
	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind == KIND_OK) |->
		(out_q.frame_length <= limit_q && out_q.frame_length <= 8'(MAX_LEN)))
		else $error("accepted frame length exceeds the limit");

	// The input side only stalls when the input register is full behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ch.ready |-> (valid_s1 && out_valid_q && !result_ch.ready))
		else $error("input stalled without a pending result");

	// Payload bytes appear only in data results.
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind != KIND_DATA) |->
		(out_q.payload_byte == 8'd0))
		else $error("payload byte set on a non-data result");

endmodule

// ===== sv/wsfr_step.sv =====
// Frame state and per-item step logic of the weighted-sum frame receiver.
// Holds phase, length, count, position and running checksum; depends on wsfr_pkg.
module wsfr_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  wsfr_pkg::item_t   item,
	input  logic [7:0]        accept_limit,
	output wsfr_pkg::result_t res
);
	import wsfr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  exp_len_q, exp_len_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  pos_q, pos_d;

	logic [7:0]  pos_inc;
	logic [7:0]  count_inc;
	logic [15:0] product;
	logic [15:0] sum_acc;
	logic        too_long;

	assign pos_inc   = pos_q + 8'd1;
	assign count_inc = count_q + 8'd1;
	assign product   = pos_inc * item.rx_byte;
	assign sum_acc   = sum_q + product;
	assign too_long  = (item.rx_byte > 8'(MAX_LEN)) || (item.rx_byte > accept_limit);

	always_comb begin
		phase_d   = phase_q;
		exp_len_d = exp_len_q;
		count_d   = count_q;
		sum_d     = sum_q;
		pos_d     = pos_q;
		res       = '{present: 1'b0, result_kind: KIND_DATA, payload_byte: 8'd0,
			frame_length: 8'd0, error_code: ERR_TOO_LONG};
		if (item.operation == OP_TIMEOUT) begin
			if (phase_q == PH_DRAIN) begin
				phase_d = PH_IDLE;
			end else if (phase_q != PH_IDLE) begin
				phase_d         = PH_IDLE;
				res.present     = 1'b1;
				res.result_kind = KIND_ERR;
				res.error_code  = ERR_TIMEOUT;
			end
		end else begin
			case (phase_q)
				PH_DATA: begin
					pos_d            = pos_inc;
					sum_d            = sum_acc;
					count_d          = count_inc;
					if (count_inc >= exp_len_q) begin
						phase_d = PH_SUMH;
					end
					res.present      = 1'b1;
					res.result_kind  = KIND_DATA;
					res.payload_byte = item.rx_byte;
				end
				PH_SUMH: begin
					if (sum_q[15:8] != item.rx_byte) begin
						phase_d         = PH_IDLE;
						res.present     = 1'b1;
						res.result_kind = KIND_ERR;
						res.error_code  = ERR_SUM_HIGH;
					end else begin
						phase_d = PH_SUML;
					end
				end
				PH_SUML: begin
					if (sum_q[7:0] != item.rx_byte) begin
						phase_d         = PH_IDLE;
						res.present     = 1'b1;
						res.result_kind = KIND_ERR;
						res.error_code  = ERR_SUM_LOW;
					end else begin
						phase_d          = PH_DRAIN;
						res.present      = 1'b1;
						res.result_kind  = KIND_OK;
						res.frame_length = exp_len_q;
					end
				end
				PH_DRAIN: begin
					phase_d = PH_DRAIN;
				end
				default: begin
					// Waiting for a length byte; the length byte itself sits at position one.
					if (too_long) begin
						phase_d         = PH_IDLE;
						res.present     = 1'b1;
						res.result_kind = KIND_ERR;
						res.error_code  = ERR_TOO_LONG;
					end else begin
						exp_len_d = item.rx_byte;
						count_d   = 8'd0;
						pos_d     = 8'd1;
						sum_d     = {8'd0, item.rx_byte};
						phase_d   = (item.rx_byte == 8'd0) ? PH_SUMH : PH_DATA;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			exp_len_q <= 8'd0;
			count_q   <= 8'd0;
			sum_q     <= 16'd0;
			pos_q     <= 8'd0;
		end else if (fire) begin
			phase_q   <= phase_d;
			exp_len_q <= exp_len_d;
			count_q   <= count_d;
			sum_q     <= sum_d;
			pos_q     <= pos_d;
		end
	end

endmodule
